@@ rtl/assert_macros.svh @@
// assertion helpers shared by the drive unit rtl
// expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// trigger implies property in the next cycle
`define ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/dwpd_pkg.sv @@
// types, constants and width helpers for the dual wheel pid drive unit
// no dependencies
`timescale 1ns / 1ps

package dwpd_pkg;

	localparam int GAIN_BITS     = 16;
	localparam int LIMIT_BITS    = 16;
	localparam int SUM_BITS      = 18;
	localparam int POWER_BITS    = 8;
	localparam int POWER_MAX     = 100;
	localparam int SETTLE_BAND   = 2;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 5;
	localparam int REG_IDX_BITS  = 3;

	// register reset values
	localparam logic [GAIN_BITS-1:0]  RESET_PROP_GAIN  = 16'd2458;
	localparam logic [GAIN_BITS-1:0]  RESET_INTEG_GAIN = 16'd0;
	localparam logic [GAIN_BITS-1:0]  RESET_DERIV_GAIN = 16'd0;
	localparam logic [LIMIT_BITS-1:0] RESET_INTEG_LIM  = 16'd50;

	// register map, word index
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_TARGET = 3'd0,
		REG_PROP   = 3'd1,
		REG_INTEG  = 3'd2,
		REG_DERIV  = 3'd3,
		REG_LIMIT  = 3'd4
	} reg_idx_t;

	// stage load enables from the pipeline control to the lanes
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic ld4;
		logic upd;
	} pipe_ctrl_t;

	// accumulator width: widest product plus room for a three term sum
	function automatic int acc_width(input int count_bits);
		int pd_w;
		int pi_w;
		pd_w = count_bits + 2 + GAIN_BITS + 1;
		pi_w = SUM_BITS + GAIN_BITS + 1;
		if (pd_w > pi_w) begin
			return pd_w + 2;
		end
		return pi_w + 2;
	endfunction

endpackage

@@ rtl/dwpd_if.sv @@
// handshake interfaces for encoder tick words and drive command words
// depends on dwpd_pkg
`timescale 1ns / 1ps

interface dwpd_tick_if #(parameter int COUNT_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic                         first_sample;
	logic signed [COUNT_BITS-1:0] left_count;
	logic signed [COUNT_BITS-1:0] right_count;

	modport source(output valid, first_sample, left_count, right_count, input ready);
	modport sink(input valid, first_sample, left_count, right_count, output ready);
endinterface

interface dwpd_drive_if import dwpd_pkg::*; ;
	logic                         valid;
	logic                         ready;
	logic signed [POWER_BITS-1:0] left_power;
	logic signed [POWER_BITS-1:0] right_power;
	logic                         settled;

	modport source(output valid, left_power, right_power, settled, input ready);
	modport sink(input valid, left_power, right_power, settled, output ready);
endinterface

@@ rtl/dual_wheel_pid_drive_unit.sv @@
// dual wheel pid drive unit: an accepted tick word passes the stage 1 to 4 registers
// and the output register to its drive word; one word per cycle sustained while
// drive.ready is high, set by the integral and previous-error update in each lane's
// second stage. every stage holds on its own, so ticks are taken while a result waits.
// arst_n clears valids, integral sums, previous errors and registers to defaults.
// depends on dwpd_pkg, dwpd_if, dwpd_lane, dwpd_merge and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_wheel_pid_drive_unit import dwpd_pkg::*; #(
	parameter int COUNT_BITS     = 24,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	dwpd_tick_if.sink                tick,
	dwpd_drive_if.source             drive
);

	localparam int ACC_W = acc_width(COUNT_BITS);
	localparam logic signed [POWER_BITS-1:0] POWER_LIM = POWER_BITS'(POWER_MAX);

	logic signed [COUNT_BITS-1:0] target_q;
	logic [GAIN_BITS-1:0]         prop_gain_q;
	logic [GAIN_BITS-1:0]         integ_gain_q;
	logic [GAIN_BITS-1:0]         deriv_gain_q;
	logic [LIMIT_BITS-1:0]        integ_limit_q;
	reg_idx_t                     reg_idx;
	logic                         reg_wr;

	logic       vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic       adv1, adv2, adv3, adv4, adv_out;
	pipe_ctrl_t pipe_ctrl;

	logic signed [ACC_W-1:0] left_acc;
	logic signed [ACC_W-1:0] right_acc;
	logic                    left_near;
	logic                    right_near;

	logic                    start_empty;
	logic                    power_ok;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= '0;
			prop_gain_q   <= RESET_PROP_GAIN;
			integ_gain_q  <= RESET_INTEG_GAIN;
			deriv_gain_q  <= RESET_DERIV_GAIN;
			integ_limit_q <= RESET_INTEG_LIM;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_TARGET: target_q      <= pwdata[COUNT_BITS-1:0];
				REG_PROP:   prop_gain_q   <= pwdata[GAIN_BITS-1:0];
				REG_INTEG:  integ_gain_q  <= pwdata[GAIN_BITS-1:0];
				REG_DERIV:  deriv_gain_q  <= pwdata[GAIN_BITS-1:0];
				REG_LIMIT:  integ_limit_q <= pwdata[LIMIT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_TARGET: prdata = APB_DATA_BITS'(target_q);
			REG_PROP:   prdata = APB_DATA_BITS'(prop_gain_q);
			REG_INTEG:  prdata = APB_DATA_BITS'(integ_gain_q);
			REG_DERIV:  prdata = APB_DATA_BITS'(deriv_gain_q);
			REG_LIMIT:  prdata = APB_DATA_BITS'(integ_limit_q);
			default:    prdata = '0;
		endcase
	end

	// per-stage flow control: a stage moves when empty or when the next one moves
	assign adv_out = !out_vld_q || drive.ready;
	assign adv4    = !vld_s4 || adv_out;
	assign adv3    = !vld_s3 || adv4;
	assign adv2    = !vld_s2 || adv3;
	assign adv1    = !vld_s1 || adv2;

	assign tick.ready    = adv1;
	assign pipe_ctrl.ld1 = adv1 && tick.valid;
	assign pipe_ctrl.ld2 = adv2 && vld_s1;
	assign pipe_ctrl.ld3 = adv3 && vld_s2;
	assign pipe_ctrl.ld4 = adv4 && vld_s3;
	assign pipe_ctrl.upd = adv2 && vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= tick.valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
			if (adv4) begin
				vld_s4 <= vld_s3;
			end
			if (adv_out) begin
				out_vld_q <= vld_s4;
			end
		end
	end

	// wheel lanes
	dwpd_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_left (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (pipe_ctrl),
		.first_sample (tick.first_sample),
		.count        (tick.left_count),
		.target       (target_q),
		.prop_gain    (prop_gain_q),
		.integ_gain   (integ_gain_q),
		.deriv_gain   (deriv_gain_q),
		.integ_limit  (integ_limit_q),
		.acc          (left_acc),
		.near         (left_near)
	);

	dwpd_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_right (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (pipe_ctrl),
		.first_sample (tick.first_sample),
		.count        (tick.right_count),
		.target       (target_q),
		.prop_gain    (prop_gain_q),
		.integ_gain   (integ_gain_q),
		.deriv_gain   (deriv_gain_q),
		.integ_limit  (integ_limit_q),
		.acc          (right_acc),
		.near         (right_near)
	);

	// merge and output register
	dwpd_merge #(
		.COUNT_BITS     (COUNT_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_merge (
		.clk         (clk),
		.load        (adv_out && vld_s4),
		.left_acc    (left_acc),
		.right_acc   (right_acc),
		.left_near   (left_near),
		.right_near  (right_near),
		.left_power  (drive.left_power),
		.right_power (drive.right_power),
		.settled     (drive.settled)
	);

	assign drive.valid = out_vld_q;

	// checks
	assign start_empty = tick.valid && tick.ready && !vld_s1 && !vld_s2 && !vld_s3
		&& !vld_s4 && !out_vld_q;
	assign power_ok    = (drive.left_power <= POWER_LIM) && (drive.left_power >= -POWER_LIM)
		&& (drive.right_power <= POWER_LIM) && (drive.right_power >= -POWER_LIM);

	`ASSERT_CLK(a_power_range, !drive.valid || power_ok, "drive power outside saturation range")
	`ASSERT_CLK(a_empty_latency, start_empty |-> ##5 drive.valid, "tick through empty pipe late")
	`ASSERT_NEXT(a_s4_hold, vld_s4 && out_vld_q && !drive.ready, vld_s4, "blocked word dropped")

endmodule

@@ rtl/dwpd_lane.sv @@
// one wheel pid lane: error, gated integral, derivative, gain products, sum
// depends on dwpd_pkg; stage enables come from the top level control
`timescale 1ns / 1ps

module dwpd_lane import dwpd_pkg::*; #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  pipe_ctrl_t                                ctrl,
	input  logic                                      first_sample,
	input  logic signed [COUNT_BITS-1:0]              count,
	input  logic signed [COUNT_BITS-1:0]              target,
	input  logic [GAIN_BITS-1:0]                      prop_gain,
	input  logic [GAIN_BITS-1:0]                      integ_gain,
	input  logic [GAIN_BITS-1:0]                      deriv_gain,
	input  logic [LIMIT_BITS-1:0]                     integ_limit,
	output logic signed [acc_width(COUNT_BITS)-1:0]   acc,
	output logic                                      near
);

	localparam int ERR_W  = COUNT_BITS + 1;
	localparam int CMP_W  = ERR_W + 2;
	localparam int ADD_W  = ((ERR_W > SUM_BITS) ? ERR_W : SUM_BITS) + 1;
	localparam int DER_W  = ERR_W + 1;
	localparam int PT_W   = GAIN_BITS + 1 + ERR_W;
	localparam int IT_W   = GAIN_BITS + 1 + SUM_BITS;
	localparam int DT_W   = GAIN_BITS + 1 + DER_W;
	localparam int ACC_W  = acc_width(COUNT_BITS);

	// stage 1 signals
	logic signed [ERR_W-1:0]      err_in;
	logic [ERR_W-1:0]             err_mag;
	logic [COUNT_BITS-1:0]        tgt_mag;
	logic [CMP_W-1:0]             err_x3;
	logic [CMP_W-1:0]             tgt_x2;
	logic signed [ERR_W-1:0]      err_s1;
	logic                         zone_s1;
	logic                         near_s1;
	logic                         first_s1;

	// stage 2 signals and loop state
	logic signed [SUM_BITS-1:0]   sum_q;
	logic signed [ERR_W-1:0]      prev_q;
	logic signed [ADD_W-1:0]      sum_add;
	logic signed [ADD_W-1:0]      lim_s;
	logic signed [SUM_BITS-1:0]   sum_nxt;
	logic signed [ERR_W-1:0]      prev_use;
	logic signed [DER_W-1:0]      der_nxt;
	logic signed [ERR_W-1:0]      err_s2;
	logic signed [SUM_BITS-1:0]   sum_s2;
	logic signed [DER_W-1:0]      der_s2;
	logic                         near_s2;

	// stage 3 and 4 signals
	logic signed [GAIN_BITS:0]    pg;
	logic signed [GAIN_BITS:0]    ig;
	logic signed [GAIN_BITS:0]    dg;
	logic signed [PT_W-1:0]       pterm_s3;
	logic signed [IT_W-1:0]       iterm_s3;
	logic signed [DT_W-1:0]       dterm_s3;
	logic                         near_s3;
	logic signed [ACC_W-1:0]      acc_s4;
	logic                         near_s4;

	// error, zone test (err nonzero and 3*|err| < 2*|target|) and settle band test
	assign err_in  = ERR_W'(target) - ERR_W'(count);
	assign err_mag = err_in[ERR_W-1] ? ERR_W'(-err_in) : err_in;
	assign tgt_mag = target[COUNT_BITS-1] ? COUNT_BITS'(-target) : target;
	assign err_x3  = CMP_W'(err_mag) + CMP_W'({err_mag, 1'b0});
	assign tgt_x2  = CMP_W'({tgt_mag, 1'b0});

	always_ff @(posedge clk) begin
		if (ctrl.ld1) begin
			err_s1   <= err_in;
			zone_s1  <= (err_mag != '0) && (err_x3 < tgt_x2);
			near_s1  <= err_mag <= ERR_W'(SETTLE_BAND);
			first_s1 <= first_sample;
		end
	end

	// integral sum with clamp, cleared outside the zone
	assign sum_add = ADD_W'(sum_q) + ADD_W'(err_s1);
	assign lim_s   = ADD_W'($signed({1'b0, integ_limit}));

	always_comb begin
		if (!zone_s1) begin
			sum_nxt = '0;
		end else if (sum_add > lim_s) begin
			sum_nxt = SUM_BITS'(lim_s);
		end else if (sum_add < -lim_s) begin
			sum_nxt = SUM_BITS'(-lim_s);
		end else begin
			sum_nxt = SUM_BITS'(sum_add);
		end
	end

	// derivative against the last error, or the target on a new move; zero when the error is zero
	assign prev_use = first_s1 ? ERR_W'(target) : prev_q;
	assign der_nxt  = (err_s1 == '0) ? '0 : DER_W'(err_s1) - DER_W'(prev_use);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
		end else if (ctrl.upd) begin
			sum_q  <= sum_nxt;
			prev_q <= err_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld2) begin
			err_s2  <= err_s1;
			sum_s2  <= sum_nxt;
			der_s2  <= der_nxt;
			near_s2 <= near_s1;
		end
	end

	// gain products
	assign pg = $signed({1'b0, prop_gain});
	assign ig = $signed({1'b0, integ_gain});
	assign dg = $signed({1'b0, deriv_gain});

	always_ff @(posedge clk) begin
		if (ctrl.ld3) begin
			pterm_s3 <= pg * err_s2;
			iterm_s3 <= ig * sum_s2;
			dterm_s3 <= dg * der_s2;
			near_s3  <= near_s2;
		end
	end

	// three term sum
	always_ff @(posedge clk) begin
		if (ctrl.ld4) begin
			acc_s4  <= ACC_W'(pterm_s3) + ACC_W'(iterm_s3) + ACC_W'(dterm_s3);
			near_s4 <= near_s3;
		end
	end

	assign acc  = acc_s4;
	assign near = near_s4;

endmodule

@@ rtl/dwpd_merge.sv @@
// merge stage: scales and saturates both lane sums, forms the settled flag
// depends on dwpd_pkg; holds the output register of the drive word
`timescale 1ns / 1ps

module dwpd_merge import dwpd_pkg::*; #(
	parameter int COUNT_BITS     = 24,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                                    clk,
	input  logic                                    load,
	input  logic signed [acc_width(COUNT_BITS)-1:0] left_acc,
	input  logic signed [acc_width(COUNT_BITS)-1:0] right_acc,
	input  logic                                    left_near,
	input  logic                                    right_near,
	output logic signed [POWER_BITS-1:0]            left_power,
	output logic signed [POWER_BITS-1:0]            right_power,
	output logic                                    settled
);

	localparam int ACC_W = acc_width(COUNT_BITS);

	logic signed [POWER_BITS-1:0] left_power_q;
	logic signed [POWER_BITS-1:0] right_power_q;
	logic                         settled_q;

	// drop the fraction toward zero, then clamp the magnitude
	function automatic logic signed [POWER_BITS-1:0] drive_power(
		input logic signed [ACC_W-1:0] sum
	);
		logic [ACC_W-1:0]      mag;
		logic [ACC_W-1:0]      whole;
		logic [POWER_BITS-1:0] lvl;
		mag   = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
		whole = mag >> GAIN_FRAC_BITS;
		lvl   = (whole > ACC_W'(POWER_MAX)) ? POWER_BITS'(POWER_MAX)
			: whole[POWER_BITS-1:0];
		return sum[ACC_W-1] ? -lvl : lvl;
	endfunction

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			left_power_q  <= drive_power(left_acc);
			right_power_q <= drive_power(right_acc);
			settled_q     <= left_near && right_near;
		end
	end

	assign left_power  = left_power_q;
	assign right_power = right_power_q;
	assign settled     = settled_q;

endmodule
